/* rtl/psc_pkg.sv */
// ----------------------------------------------------------------------------
// psc_pkg
// Types, constants and helper functions shared by the phoneme synthesizer
// control sequencer.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_COMMIT = 1'b1
  } cmd_e;

  localparam int NumRegs = 7;
  localparam int IX_FA   = 0;
  localparam int IX_FC   = 1;
  localparam int IX_VA   = 2;
  localparam int IX_F1   = 3;
  localparam int IX_F2   = 4;
  localparam int IX_F2Q  = 5;
  localparam int IX_F3   = 6;

  localparam logic [5:0]  DIV_LAST     = 6'd47;
  localparam logic [5:0]  DIV_TICK48   = 6'h28;
  localparam logic [4:0]  TICKS_DONE   = 5'h10;
  localparam logic [4:0]  RAMP_MAX     = 5'(7 << 2);
  localparam logic [7:0]  PITCH_BASE   = 8'hE0;
  localparam logic [7:0]  COMMIT_MASK  = 8'hF9;
  localparam logic [7:0]  COMMIT_MATCH = 8'h08;
  localparam logic [14:0] NOISE_FULL   = 15'h7FFF;

  typedef struct packed {
    logic [1:0]                 inflection;
    logic [6:0]                 duration;
    logic [3:0]                 cld;
    logic [3:0]                 vd;
    logic                       closure;
    logic                       pause;
    logic [NumRegs-1:0][4:0]    tgt;
  } params_t;

  typedef struct packed {
    logic [8:0]                 subtick;
    logic [4:0]                 ticks;
    logic [5:0]                 divider;
    logic [NumRegs-1:0][7:0]    interp;
    logic [NumRegs-1:0][4:0]    latched;
    logic [4:0]                 ramp;
    logic                       closure_active;
    logic [7:0]                 pitch;
    logic [14:0]                noise_shift;
    logic                       noise_out;
  } state_t;

  // The stop phoneme after reset: closure and pause set, everything else clear.
  localparam state_t  StateReset  = '{closure_active: 1'b1, default: '0};
  localparam params_t ParamsReset = '{closure: 1'b1, pause: 1'b1, default: '0};

  // One step of the interpolator: the register loses an eighth of itself and
  // gains twice the target.
  function automatic logic [7:0] decay_step(logic [7:0] r, logic [4:0] tgt);
    return r - {3'b000, r[7:3]} + {2'b00, tgt, 1'b0};
  endfunction

endpackage

/* rtl/psc_if.sv */
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channels of the control sequencer: the request channel that
// carries commit and sample tick transactions, and the result channel.
// ----------------------------------------------------------------------------
interface psc_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  inflection_level;
  logic [6:0]  duration_code;
  logic [3:0]  closure_delay;
  logic [3:0]  voice_delay;
  logic        closure_flag;
  logic        pause_flag;
  logic [16:0] formant_targets;
  logic [11:0] amplitude_targets;

  modport source (
    output valid, command, inflection_level, duration_code, closure_delay,
           voice_delay, closure_flag, pause_flag, formant_targets,
           amplitude_targets,
    input  ready
  );
  modport sink (
    input  valid, command, inflection_level, duration_code, closure_delay,
           voice_delay, closure_flag, pause_flag, formant_targets,
           amplitude_targets,
    output ready
  );
endinterface

interface psc_rsp_if;
  logic       valid;
  logic       ready;
  logic       phone_done;
  logic [7:0] pitch_phase;
  logic [4:0] closure_level;
  logic       noise_bit;
  logic [3:0] f1_code;
  logic [4:0] f2_code;
  logic [3:0] f2q_code;
  logic [3:0] f3_code;
  logic [3:0] noise_amp_code;
  logic [3:0] noise_mix_code;
  logic [3:0] voice_amp_code;
  logic       filters_committed;

  modport source (
    output valid, phone_done, pitch_phase, closure_level, noise_bit, f1_code,
           f2_code, f2q_code, f3_code, noise_amp_code, noise_mix_code,
           voice_amp_code, filters_committed,
    input  ready
  );
  modport sink (
    input  valid, phone_done, pitch_phase, closure_level, noise_bit, f1_code,
           f2_code, f2q_code, f3_code, noise_amp_code, noise_mix_code,
           voice_amp_code, filters_committed,
    output ready
  );
endinterface

/* rtl/psc_update.sv */
// ----------------------------------------------------------------------------
// psc_update
// Next-state logic of one synthesizer update: duration and divider counters,
// interpolators, closure ramp, pitch counter with filter commit, noise LFSR.
// ----------------------------------------------------------------------------
module psc_update
  import psc_pkg::*;
(
  input  state_t  state_i,
  input  params_t params_i,
  output state_t  state_o,
  output logic    committed_o
);

  logic [8:0] sub_inc;
  logic [4:0] ticks_inc;
  logic [7:0] pitch_inc;
  logic [8:0] period_end;
  logic       amp_on;
  logic       tick16;
  logic       tick48;
  logic       feed;

  assign sub_inc   = state_i.subtick + 9'd1;
  assign ticks_inc = state_i.ticks + 5'd1;
  assign pitch_inc = state_i.pitch + 8'd1;
  assign amp_on    = (state_i.latched[IX_FA] != 5'd0) || (state_i.latched[IX_VA] != 5'd0);
  assign period_end = {1'b0, PITCH_BASE ^ {1'b0, params_i.inflection, 5'b00000}
                       ^ {3'b000, state_i.latched[IX_F1][3:0], 1'b0}} + 9'd2;
  assign feed = state_i.noise_out && (state_i.noise_shift != NOISE_FULL);

  always_comb begin
    state_o     = state_i;
    committed_o = 1'b0;

    if (state_i.ticks != TICKS_DONE) begin
      if (sub_inc == {params_i.duration, 2'b01}) begin
        state_o.subtick = 9'd0;
        state_o.ticks   = ticks_inc;
        if (ticks_inc == {1'b0, params_i.cld}) begin
          state_o.closure_active = params_i.closure;
        end
      end else begin
        state_o.subtick = sub_inc;
      end
    end

    state_o.divider = (state_i.divider == DIV_LAST) ? 6'd0 : state_i.divider + 6'd1;
    tick16 = (state_o.divider[3:0] == 4'd0);
    tick48 = (state_o.divider == DIV_TICK48);

    if (tick48 && (!params_i.pause || !amp_on)) begin
      state_o.interp[IX_FC]  = decay_step(state_i.interp[IX_FC], params_i.tgt[IX_FC]);
      state_o.interp[IX_F1]  = decay_step(state_i.interp[IX_F1], params_i.tgt[IX_F1]);
      state_o.interp[IX_F2]  = decay_step(state_i.interp[IX_F2], params_i.tgt[IX_F2]);
      state_o.interp[IX_F2Q] = decay_step(state_i.interp[IX_F2Q], params_i.tgt[IX_F2Q]);
      state_o.interp[IX_F3]  = decay_step(state_i.interp[IX_F3], params_i.tgt[IX_F3]);
    end

    if (tick16) begin
      if (state_o.ticks >= {1'b0, params_i.vd}) begin
        state_o.interp[IX_FA] = decay_step(state_i.interp[IX_FA], params_i.tgt[IX_FA]);
      end
      if (state_o.ticks >= {1'b0, params_i.cld}) begin
        state_o.interp[IX_VA] = decay_step(state_i.interp[IX_VA], params_i.tgt[IX_VA]);
      end
    end

    if (!state_o.closure_active && amp_on) begin
      state_o.ramp = 5'd0;
    end else if (state_i.ramp != RAMP_MAX) begin
      state_o.ramp = state_i.ramp + 5'd1;
    end

    state_o.pitch = ({1'b0, pitch_inc} == period_end) ? 8'd0 : pitch_inc;

    if ((state_o.pitch & COMMIT_MASK) == COMMIT_MATCH) begin
      for (int i = 0; i < NumRegs; i++) begin
        if (i == IX_F2) begin
          state_o.latched[i] = state_o.interp[i][7:3];
        end else begin
          state_o.latched[i] = {1'b0, state_o.interp[i][7:4]};
        end
      end
      committed_o = 1'b1;
    end

    state_o.noise_shift = {state_i.noise_shift[13:0], feed};
    state_o.noise_out   = ~(state_o.noise_shift[14] ^ state_o.noise_shift[13]);
  end

endmodule

/* rtl/phoneme_synth_control_sequencer_core.sv */
// ----------------------------------------------------------------------------
// phoneme_synth_control_sequencer_core
// Control sequencer of a phoneme speech synthesizer.
// ----------------------------------------------------------------------------
// Every request transaction, either a phoneme commit or a sample tick, yields
// exactly one result transaction, which appears in the cycle after the
// request is accepted. A new request is accepted in every cycle in which
// the result register is empty or its result is being taken, so the
// sustained rate is one transaction per cycle; it is set by the single
// combinational update path between the sequencer state registers, which
// also serve as the result register. Odd sample ticks leave the state
// unchanged and report it with the filter commit flag clear.
// ----------------------------------------------------------------------------
module phoneme_synth_control_sequencer_core
  import psc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  psc_req_if.sink   req,
  psc_rsp_if.source rsp
);

  state_t  state_q, state_d, state_upd, state_commit;
  params_t params_q, params_d, params_new;
  logic    phase_q, phase_d;
  logic    rsp_valid_q, rsp_valid_d;
  logic    committed_q, committed_d;
  logic    upd_committed;
  logic    accept;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;

  psc_update u_update (
    .state_i     (state_q),
    .params_i    (params_q),
    .state_o     (state_upd),
    .committed_o (upd_committed)
  );

  always_comb begin
    params_new.inflection = req.inflection_level;
    params_new.duration   = req.duration_code;
    params_new.cld        = req.closure_delay;
    params_new.vd         = req.voice_delay;
    params_new.closure    = req.closure_flag;
    params_new.pause      = req.pause_flag;
    params_new.tgt[IX_F1]  = {1'b0, req.formant_targets[3:0]};
    params_new.tgt[IX_F2]  = req.formant_targets[8:4];
    params_new.tgt[IX_F2Q] = {1'b0, req.formant_targets[12:9]};
    params_new.tgt[IX_F3]  = {1'b0, req.formant_targets[16:13]};
    params_new.tgt[IX_FA]  = {1'b0, req.amplitude_targets[3:0]};
    params_new.tgt[IX_FC]  = {1'b0, req.amplitude_targets[7:4]};
    params_new.tgt[IX_VA]  = {1'b0, req.amplitude_targets[11:8]};

    state_commit         = state_q;
    state_commit.subtick = 9'd0;
    state_commit.ticks   = 5'd0;
    if (req.closure_delay == 4'd0) begin
      state_commit.closure_active = req.closure_flag;
    end
  end

  always_comb begin
    state_d     = state_q;
    params_d    = params_q;
    phase_d     = phase_q;
    committed_d = committed_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (accept) begin
      rsp_valid_d = 1'b1;
      committed_d = 1'b0;
      if (req.command == CMD_COMMIT) begin
        params_d = params_new;
        state_d  = state_commit;
      end else begin
        phase_d = ~phase_q;
        if (phase_q) begin
          state_d     = state_upd;
          committed_d = upd_committed;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      params_q    <= ParamsReset;
      phase_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
      committed_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      params_q    <= params_d;
      phase_q     <= phase_d;
      rsp_valid_q <= rsp_valid_d;
      committed_q <= committed_d;
    end
  end

  assign rsp.valid             = rsp_valid_q;
  assign rsp.phone_done        = (state_q.ticks >= TICKS_DONE);
  assign rsp.pitch_phase       = state_q.pitch;
  assign rsp.closure_level     = state_q.ramp;
  assign rsp.noise_bit         = state_q.noise_out;
  assign rsp.f1_code           = state_q.latched[IX_F1][3:0];
  assign rsp.f2_code           = state_q.latched[IX_F2];
  assign rsp.f2q_code          = state_q.latched[IX_F2Q][3:0];
  assign rsp.f3_code           = state_q.latched[IX_F3][3:0];
  assign rsp.noise_amp_code    = state_q.latched[IX_FA][3:0];
  assign rsp.noise_mix_code    = state_q.latched[IX_FC][3:0];
  assign rsp.voice_amp_code    = state_q.latched[IX_VA][3:0];
  assign rsp.filters_committed = committed_q;

  // The duration tick count saturates at sixteen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ticks <= TICKS_DONE)
    else $error("phone tick count exceeded its end value");

  // The update divider cycles through forty-eight steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.divider <= DIV_LAST)
    else $error("update divider out of range");

  // The closure ramp never runs past its ceiling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ramp <= RAMP_MAX)
    else $error("closure ramp out of range");

  // A filter commit is only reported at the matching pitch phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && committed_q) |-> ((state_q.pitch & COMMIT_MASK) == COMMIT_MATCH))
    else $error("filter commit reported at a wrong pitch phase");

  // A sample tick that lands on an odd sample leaves the pitch counter alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.command == CMD_TICK && !phase_q) |=> $stable(state_q.pitch))
    else $error("pitch counter moved on a skipped sample");

endmodule
